// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL of the process priority queue, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge while rst is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/ppq_pkg.sv -----
// Package with the sizes, codes and record type of the process priority queue.
package ppq_pkg;

  localparam int DEPTH   = 16;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;
  localparam int ID_W    = 16;
  localparam int NAME_W  = 64;
  localparam int PRIO_W  = 7;
  localparam int BURST_W = 16;
  localparam int OCC_W   = 5;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_OLDEST = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PRIOR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [NAME_W-1:0]  name;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } rec_t;

endpackage

// ----- sv/ppq_in_if.sv -----
// Request channel of the process priority queue.
interface ppq_in_if;
  logic                         valid;
  logic                         ready;
  logic [ppq_pkg::REQ_W-1:0]    req_type;
  logic [ppq_pkg::ID_W-1:0]     process_id;
  logic [ppq_pkg::NAME_W-1:0]   process_name;
  logic [ppq_pkg::PRIO_W-1:0]   priority_req;
  logic [ppq_pkg::BURST_W-1:0]  burst_time;

  modport source (
    output valid, req_type, process_id, process_name, priority_req, burst_time,
    input  ready
  );

  modport sink (
    input  valid, req_type, process_id, process_name, priority_req, burst_time,
    output ready
  );
endinterface

// ----- sv/ppq_out_if.sv -----
// Result channel of the process priority queue.
interface ppq_out_if;
  logic                         valid;
  logic                         ready;
  logic [ppq_pkg::STAT_W-1:0]   status;
  logic [ppq_pkg::ID_W-1:0]     out_id;
  logic [ppq_pkg::NAME_W-1:0]   out_name;
  logic [ppq_pkg::PRIO_W-1:0]   out_priority;
  logic [ppq_pkg::BURST_W-1:0]  out_burst;
  logic [ppq_pkg::OCC_W-1:0]    occupancy;

  modport source (
    output valid, status, out_id, out_name, out_priority, out_burst, occupancy,
    input  ready
  );

  modport sink (
    input  valid, status, out_id, out_name, out_priority, out_burst, occupancy,
    output ready
  );
endinterface

// ----- sv/process_priority_queue_top.sv -----
// Top level of the process priority queue: record store, scan sequencer and result register.
//
// Channel   Dir   Carries
// -------   ---   ---------------------------------------------------------
// req       in    req_type, process_id, process_name, priority_req, burst_time
// rsp       out   status, out_id, out_name, out_priority, out_burst, occupancy
//
// An insert, an unused code or a removal on an empty queue goes straight to the
// result step. The oldest and the priority removal are both paced by the single
// read port of the record memory, which the priority scan and the gap closing
// walk one slot per cycle. rst is synchronous and empties the queue; the record
// memory itself is not cleared. The block takes one request beat at a time and
// raises req.ready only when idle. A result beat waits in the output register
// while rsp.ready is low, and the block may accept and work the next request
// meanwhile, holding that result until the register frees up.
module process_priority_queue_top (
  input  logic       clk,
  input  logic       rst,
  ppq_in_if.sink     req,
  ppq_out_if.source  rsp
);

  `include "assert_macros.svh"

  localparam int ADDR_W = ppq_pkg::ADDR_W;
  localparam int CNT_W  = ppq_pkg::CNT_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ppq_pkg::DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request beat
  localparam logic [2:0] S_SCAN  = 3'd1;  // walking the priorities for the minimum
  localparam logic [2:0] S_TAKE  = 3'd2;  // reading the chosen slot
  localparam logic [2:0] S_GRAB  = 3'd3;  // capturing the chosen record
  localparam logic [2:0] S_SHIFT = 3'd4;  // moving later records down one slot
  localparam logic [2:0] S_RESP  = 3'd5;  // handing the result to the output register

  logic [2:0]                  state;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            idx;
  logic [ADDR_W-1:0]           best;
  logic [ppq_pkg::PRIO_W-1:0]  bestp;
  logic                        pend;
  logic [ADDR_W-1:0]           pend_idx;
  logic [ppq_pkg::STAT_W-1:0]  res_status;
  ppq_pkg::rec_t               res_rec;

  // Record memory: one write port, one registered read port.
  ppq_pkg::rec_t               mem [ppq_pkg::DEPTH];
  ppq_pkg::rec_t               rd_data;
  logic [ADDR_W-1:0]           rd_addr;
  logic                        we;
  logic [ADDR_W-1:0]           wr_addr;
  ppq_pkg::rec_t               wr_data;

  logic                        accept;
  logic                        issuing;
  logic                        prio_less;
  logic                        out_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  // Compare logic: the index walk, used by the scan and the shift, and the priority compare.
  assign issuing   = (idx < count);
  assign prio_less = (rd_data.prio < bestp);

  // The scan and the shift walk the index; the take step reads the winner.
  always_comb begin
    if (state == S_TAKE) begin
      rd_addr = best;
    end else begin
      rd_addr = idx[ADDR_W-1:0];
    end
  end

  // An insert writes at the tail; the shift writes each record one slot lower.
  always_comb begin
    we      = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    wr_data = '{id:    req.process_id,
                name:  req.process_name,
                prio:  req.priority_req,
                burst: req.burst_time};
    if (accept && (req.req_type == ppq_pkg::REQ_INSERT) && (count != DEPTH_CNT)) begin
      we = 1'b1;
    end else if ((state == S_SHIFT) && pend) begin
      we      = 1'b1;
      wr_addr = pend_idx - ADDR_W'(1);
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= ppq_pkg::ST_DONE;
            res_rec    <= '0;
            idx        <= '0;
            best       <= '0;
            pend       <= 1'b0;
            state      <= S_RESP;
            case (req.req_type) inside
              ppq_pkg::REQ_INSERT: begin
                if (count == DEPTH_CNT) begin
                  res_status <= ppq_pkg::ST_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              ppq_pkg::REQ_OLDEST, ppq_pkg::REQ_PRIOR: begin
                if (count == '0) begin
                  res_status <= ppq_pkg::ST_EMPTY;
                end else if (req.req_type == ppq_pkg::REQ_PRIOR) begin
                  state <= S_SCAN;
                end else begin
                  state <= S_TAKE;
                end
              end
              default: begin
                // The unused code leaves the queue as it is.
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issuing) begin
            idx <= idx + CNT_W'(1);
          end
          pend     <= issuing;
          pend_idx <= idx[ADDR_W-1:0];
          // Slot zero seeds the minimum; a later slot wins only when strictly smaller.
          if (pend && ((pend_idx == '0) || prio_less)) begin
            best  <= pend_idx;
            bestp <= rd_data.prio;
          end
          if (!issuing) begin
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          pend  <= 1'b0;
          idx   <= CNT_W'(best) + CNT_W'(1);
          state <= S_GRAB;
        end
        S_GRAB: begin
          res_rec <= rd_data;
          state   <= S_SHIFT;
        end
        S_SHIFT: begin
          if (issuing) begin
            idx <= idx + CNT_W'(1);
          end
          pend     <= issuing;
          pend_idx <= idx[ADDR_W-1:0];
          if (!issuing && !pend) begin
            count <= count - CNT_W'(1);
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded from the result once the previous beat has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == S_RESP) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      rsp.status       <= res_status;
      rsp.out_id       <= res_rec.id;
      rsp.out_name     <= res_rec.name;
      rsp.out_priority <= res_rec.prio;
      rsp.out_burst    <= res_rec.burst;
      rsp.occupancy    <= ppq_pkg::OCC_W'(count);
    end
  end

  `ASSERT_CLK(a_count_bound, count <= DEPTH_CNT, "record count exceeds the queue depth")
  `ASSERT_CLK(a_insert_grows,
    (accept && (req.req_type == ppq_pkg::REQ_INSERT) && (count != DEPTH_CNT)) |=>
      (count == $past(count) + CNT_W'(1)),
    "accepted insert did not add one record")
  `ASSERT_CLK(a_scan_in_range, (state == S_SCAN) |-> (idx <= count),
    "priority scan ran past the last record")
  `ASSERT_CLK(a_shift_not_slot0, ((state == S_SHIFT) && pend) |-> (pend_idx != '0),
    "gap closing tried to move slot zero")
  `ASSERT_ALWAYS(a_reset_idle, rst |=> ((state == S_IDLE) && (count == '0) && !rsp.valid),
    "reset did not empty the queue")

endmodule
